>>> hdl/dssq_pkg.sv
`default_nettype none

package dssq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    // Field widths
    localparam int TASK_W   = 15;
    localparam int SEC_W    = 32;
    localparam int SUB_W    = 20;
    localparam int STATUS_W = 3;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 24;

    // Command carried on s_tuser
    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_CANCEL = 2'd2
    } mode_t;

    // Result status codes
    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_INSERTED  = 3'd0;
    localparam status_t ST_FULL      = 3'd1;
    localparam status_t ST_NOT_FOUND = 3'd2;
    localparam status_t ST_EXPIRED   = 3'd3;
    localparam status_t ST_IDLE      = 3'd4;

    // One queued wait
    typedef struct packed {
        logic [SEC_W-1:0]  sec;
        logic [SUB_W-1:0]  sub;
        logic [TASK_W-1:0] task_id;
        logic              file_wait;
    } entry_t;

    // Operation broadcast to the row of cells
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP,
        CELL_CANCEL
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   key;
    } cell_ctrl_t;

    // Sequencer states
    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_INSERT,
        FSM_TICK,
        FSM_CANCEL
    } fsm_t;

endpackage

`default_nettype wire

>>> hdl/dssq_cell.sv
`default_nettype none

module dssq_cell (
    input  wire                  aclk,
    input  dssq_pkg::cell_ctrl_t ctrl,
    input  wire                  occupied,
    input  dssq_pkg::entry_t     left_entry,
    input  wire                  left_ge,
    input  dssq_pkg::entry_t     right_entry,
    input  wire                  found_in,
    output dssq_pkg::entry_t     entry,
    output logic                 ge,
    output logic                 due,
    output logic                 found_out
);

    dssq_pkg::entry_t entry_reg;
    dssq_pkg::entry_t entry_next;
    logic             later;
    logic             match;

    // Compare own deadline against the broadcast key
    always_comb begin
        later = (entry_reg.sec > ctrl.key.sec) ||
                ((entry_reg.sec == ctrl.key.sec) && (entry_reg.sub > ctrl.key.sub));
        match = occupied && (entry_reg.task_id == ctrl.key.task_id);
    end

    // Empty cells sit past the insertion point
    assign ge        = !occupied || later;
    assign due       = !later;
    assign found_out = found_in || match;
    assign entry     = entry_reg;

    // Choose own, left neighbor's, right neighbor's or the new entry
    always_comb begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            dssq_pkg::CELL_INSERT: begin
                if (left_ge) begin
                    entry_next = left_entry;
                end else if (ge) begin
                    entry_next = ctrl.key;
                end
            end
            dssq_pkg::CELL_POP: begin
                entry_next = right_entry;
            end
            dssq_pkg::CELL_CANCEL: begin
                if (found_out) begin
                    entry_next = right_entry;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

>>> hdl/deadline_sorted_sleep_queue_top.sv
`default_nettype none

// Deadline-sorted sleep queue: a row of QUEUE_DEPTH cells holds timed waits
// ordered by deadline (seconds, then subseconds as a plain 20-bit number),
// head in cell 0. s_tuser selects insert, tick or cancel; mode 3 is dropped
// without a result. An insert or a cancel is accepted, then updates the row
// at most once and gives one word. A tick pops k entries (k at most
// MAX_RESULTS) and gives one word per pop; the row shifts by one cell a cycle
// unless the output stalls, and a tick with nothing due gives one word.
// m_tlast marks the final word of each command. A new word is accepted
// once the previous command has handed its last word to the output register.
module deadline_sorted_sleep_queue_top (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    // task_id[14:0], time_sec[46:15], time_sub[66:47], wait_kind[67], zero fill
    input  wire  [dssq_pkg::S_DATA_W-1:0]  s_tdata,
    // mode[1:0]
    input  wire  [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // status[2:0], woken_task[17:3], was_file_wait[18], zero fill
    output logic [dssq_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                           m_tlast
);

    localparam int N = dssq_pkg::QUEUE_DEPTH;

    dssq_pkg::fsm_t                    state_reg, state_next;
    dssq_pkg::entry_t                  cmd_reg, cmd_next;
    logic [dssq_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [dssq_pkg::RES_W-1:0]        n_reg, n_next;
    logic                              m_tvalid_reg, m_tvalid_next;
    dssq_pkg::status_t                 status_reg, status_next;
    logic [dssq_pkg::TASK_W-1:0]       woken_reg, woken_next;
    logic                              fw_reg, fw_next;
    logic                              last_reg, last_next;

    dssq_pkg::cell_ctrl_t              cell_ctrl;
    dssq_pkg::entry_t                  cell_entry [N];
    logic [N-1:0]                      cell_ge;
    logic [N-1:0]                      cell_due;
    logic [N-1:0]                      cell_found;
    logic [N-1:0]                      cell_occ;

    dssq_pkg::mode_t                   in_mode;
    dssq_pkg::entry_t                  in_entry;
    logic                              out_free;
    logic                              tick_pop;
    logic                              tick_last_pop;
    logic                              tick_done;
    logic                              full;
    logic                              found;

    // Unpack the input word
    assign in_mode            = dssq_pkg::mode_t'(s_tuser);
    assign in_entry.task_id   = s_tdata[14:0];
    assign in_entry.sec       = s_tdata[46:15];
    assign in_entry.sub       = s_tdata[66:47];
    assign in_entry.file_wait = s_tdata[67];

    assign s_tready = (state_reg == dssq_pkg::FSM_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    // Row of cells, neighbors wired left and right
    genvar i;
    generate
        for (i = 0; i < N; i++) begin : g_cell
            dssq_pkg::entry_t left_e;
            dssq_pkg::entry_t right_e;
            logic             left_g;
            logic             found_i;

            assign cell_occ[i] = (count_reg > dssq_pkg::CNT_W'(i));

            if (i == 0) begin : g_head
                assign left_e  = cmd_reg;
                assign left_g  = 1'b0;
                assign found_i = 1'b0;
            end else begin : g_body
                assign left_e  = cell_entry[i-1];
                assign left_g  = cell_ge[i-1];
                assign found_i = cell_found[i-1];
            end

            if (i == N - 1) begin : g_tail
                assign right_e = cell_entry[i];
            end else begin : g_inner
                assign right_e = cell_entry[i+1];
            end

            dssq_cell u_cell (
                .aclk        (aclk),
                .ctrl        (cell_ctrl),
                .occupied    (cell_occ[i]),
                .left_entry  (left_e),
                .left_ge     (left_g),
                .right_entry (right_e),
                .found_in    (found_i),
                .entry       (cell_entry[i]),
                .ge          (cell_ge[i]),
                .due         (cell_due[i]),
                .found_out   (cell_found[i])
            );
        end
    endgenerate

    // Full and found flags, and head status for the tick drain
    assign full          = (count_reg == dssq_pkg::CNT_W'(N));
    assign found         = cell_found[N-1];
    assign tick_pop      = (count_reg != '0) && cell_due[0] &&
                           (n_reg != dssq_pkg::RES_W'(dssq_pkg::MAX_RESULTS));
    assign tick_last_pop = !((count_reg > dssq_pkg::CNT_W'(1)) && cell_due[1] &&
                             (n_reg != dssq_pkg::RES_W'(dssq_pkg::MAX_RESULTS - 1)));
    assign tick_done     = !tick_pop || tick_last_pop;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dssq_pkg::FSM_IDLE: begin
                if (s_tvalid) begin
                    unique case (in_mode)
                        dssq_pkg::MODE_INSERT: state_next = dssq_pkg::FSM_INSERT;
                        dssq_pkg::MODE_TICK:   state_next = dssq_pkg::FSM_TICK;
                        dssq_pkg::MODE_CANCEL: state_next = dssq_pkg::FSM_CANCEL;
                        default:               state_next = dssq_pkg::FSM_IDLE;
                    endcase
                end
            end
            dssq_pkg::FSM_INSERT,
            dssq_pkg::FSM_CANCEL: begin
                if (out_free) begin
                    state_next = dssq_pkg::FSM_IDLE;
                end
            end
            dssq_pkg::FSM_TICK: begin
                if (out_free && tick_done) begin
                    state_next = dssq_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = dssq_pkg::FSM_IDLE;
            end
        endcase
    end

    // Row operation, count and result word
    always_comb begin
        cmd_next       = cmd_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        cell_ctrl.op   = dssq_pkg::CELL_HOLD;
        cell_ctrl.key  = cmd_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        status_next    = status_reg;
        woken_next     = woken_reg;
        fw_next        = fw_reg;
        last_next      = last_reg;

        unique case (state_reg)
            dssq_pkg::FSM_IDLE: begin
                if (s_tvalid) begin
                    cmd_next = in_entry;
                    n_next   = '0;
                end
            end
            dssq_pkg::FSM_INSERT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    woken_next    = '0;
                    fw_next       = 1'b0;
                    last_next     = 1'b1;
                    if (full) begin
                        status_next = dssq_pkg::ST_FULL;
                    end else begin
                        cell_ctrl.op = dssq_pkg::CELL_INSERT;
                        count_next   = count_reg + dssq_pkg::CNT_W'(1);
                        status_next  = dssq_pkg::ST_INSERTED;
                    end
                end
            end
            dssq_pkg::FSM_CANCEL: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    fw_next       = 1'b0;
                    last_next     = 1'b1;
                    if (found) begin
                        cell_ctrl.op = dssq_pkg::CELL_CANCEL;
                        count_next   = count_reg - dssq_pkg::CNT_W'(1);
                        status_next  = dssq_pkg::ST_IDLE;
                        woken_next   = cmd_reg.task_id;
                    end else begin
                        status_next = dssq_pkg::ST_NOT_FOUND;
                        woken_next  = '0;
                    end
                end
            end
            dssq_pkg::FSM_TICK: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    if (tick_pop) begin
                        cell_ctrl.op = dssq_pkg::CELL_POP;
                        count_next   = count_reg - dssq_pkg::CNT_W'(1);
                        n_next       = n_reg + dssq_pkg::RES_W'(1);
                        status_next  = dssq_pkg::ST_EXPIRED;
                        woken_next   = cell_entry[0].task_id;
                        fw_next      = cell_entry[0].file_wait;
                        last_next    = tick_last_pop;
                    end else begin
                        status_next = dssq_pkg::ST_IDLE;
                        woken_next  = '0;
                        fw_next     = 1'b0;
                        last_next   = 1'b1;
                    end
                end
            end
            default: begin
                cell_ctrl.op = dssq_pkg::CELL_HOLD;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dssq_pkg::FSM_IDLE;
            count_reg    <= '0;
            n_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            n_reg        <= n_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        status_reg <= status_next;
        woken_reg  <= woken_next;
        fw_reg     <= fw_next;
        last_reg   <= last_next;
    end

    // Pack the output word
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, fw_reg, woken_reg, status_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

>>> verif/deadline_sorted_sleep_queue_top_tb.sv
`timescale 1ns / 1ps

module deadline_sorted_sleep_queue_top_tb;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned RUN_LIMIT_NS = 1_000_000;
    localparam int PRINT_LIMIT = 40;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [dssq_pkg::SEC_W-1:0] SEC_MAX = '1;
    localparam logic [dssq_pkg::SUB_W-1:0] SUB_MAX = '1;

    typedef struct packed {
        dssq_pkg::status_t           status;
        logic [dssq_pkg::TASK_W-1:0] task_id;
        logic                        file_wait;
        logic                        last;
    } reply_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [dssq_pkg::S_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]                     s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [dssq_pkg::M_DATA_W-1:0]  m_tdata;
    logic                           m_tlast;

    // Shadow copy of the sleep queue, head at index 0
    dssq_pkg::entry_t               shadow_q[dssq_pkg::QUEUE_DEPTH];
    int                             shadow_count = 0;
    reply_t                         awaited_replies[$];

    int                             error_count = 0;
    int                             tx_burst_left = 0;
    bit                             tx_gaps_on = 1'b1;
    int                             rx_hold_req = 0;

    // Wall clock of the random traffic and a pool of task ids
    logic [dssq_pkg::SEC_W-1:0]     now_sec;
    logic [dssq_pkg::SUB_W-1:0]     now_sub;
    logic [dssq_pkg::TASK_W-1:0]    task_pool[16];

    deadline_sorted_sleep_queue_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    // Deadline of queue entry idx is strictly after (sec, sub)
    function automatic bit due_after(int idx, logic [dssq_pkg::SEC_W-1:0] sec,
                                     logic [dssq_pkg::SUB_W-1:0] sub);
        return shadow_q[idx].sec > sec || (shadow_q[idx].sec == sec && shadow_q[idx].sub > sub);
    endfunction

    function automatic void drop_entry(int pos);
        for (int i = pos; i + 1 < shadow_count; i++)
            shadow_q[i] = shadow_q[i + 1];
        shadow_count--;
    endfunction

    function automatic void await_reply(dssq_pkg::status_t st,
                                        logic [dssq_pkg::TASK_W-1:0] tid,
                                        logic fw, logic last);
        reply_t r;
        r.status = st;
        r.task_id = tid;
        r.file_wait = fw;
        r.last = last;
        awaited_replies.push_back(r);
    endfunction

    // Apply one accepted command to the shadow queue and queue up its replies
    function automatic void apply_sleep_command(logic [1:0] mode,
                                                logic [dssq_pkg::TASK_W-1:0] tid,
                                                logic [dssq_pkg::SEC_W-1:0] sec,
                                                logic [dssq_pkg::SUB_W-1:0] sub,
                                                logic kind);
        int pos;
        int popped;
        bit found;
        case (mode)
            dssq_pkg::MODE_INSERT: begin
                if (shadow_count >= dssq_pkg::QUEUE_DEPTH) begin
                    await_reply(dssq_pkg::ST_FULL, '0, 1'b0, 1'b1);
                end else begin
                    pos = 0;
                    while (pos < shadow_count && !due_after(pos, sec, sub))
                        pos++;
                    for (int i = shadow_count; i > pos; i--)
                        shadow_q[i] = shadow_q[i - 1];
                    shadow_q[pos].sec = sec;
                    shadow_q[pos].sub = sub;
                    shadow_q[pos].task_id = tid;
                    shadow_q[pos].file_wait = kind;
                    shadow_count++;
                    await_reply(dssq_pkg::ST_INSERTED, '0, 1'b0, 1'b1);
                end
            end
            dssq_pkg::MODE_TICK: begin
                popped = 0;
                while (popped < dssq_pkg::MAX_RESULTS && shadow_count > 0 &&
                       !due_after(0, sec, sub)) begin
                    await_reply(dssq_pkg::ST_EXPIRED, shadow_q[0].task_id,
                                shadow_q[0].file_wait, 1'b0);
                    drop_entry(0);
                    popped++;
                end
                if (popped == 0)
                    await_reply(dssq_pkg::ST_IDLE, '0, 1'b0, 1'b1);
                else
                    awaited_replies[awaited_replies.size() - 1].last = 1'b1;
            end
            dssq_pkg::MODE_CANCEL: begin
                found = 1'b0;
                for (int i = 0; i < shadow_count && !found; i++) begin
                    if (shadow_q[i].task_id == tid) begin
                        drop_entry(i);
                        found = 1'b1;
                    end
                end
                if (found)
                    await_reply(dssq_pkg::ST_IDLE, tid, 1'b0, 1'b1);
                else
                    await_reply(dssq_pkg::ST_NOT_FOUND, '0, 1'b0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    // Offer one word, idling between bursts, and model it once accepted
    task automatic send_word(input logic [1:0] mode, input logic [dssq_pkg::TASK_W-1:0] tid,
                             input logic [dssq_pkg::SEC_W-1:0] sec,
                             input logic [dssq_pkg::SUB_W-1:0] sub,
                             input logic kind);
        int gap;
        if (tx_gaps_on) begin
            if (tx_burst_left == 0) begin
                tx_burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            tx_burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, kind, sub, sec, tid};
        s_tuser  <= mode;
        do @(posedge aclk); while (s_tready !== 1'b1);
        apply_sleep_command(mode, tid, sec, sub, kind);
    endtask

    task automatic wait_replies_drained();
        s_tvalid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge aclk);
    endtask

    // Check each delivered word against the oldest awaited reply
    always @(posedge aclk) begin : check_replies
        reply_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (awaited_replies.size() == 0) begin
                report_mismatch("word with nothing awaited", int'(m_tdata), 0);
            end else begin
                want = awaited_replies.pop_front();
                if (m_tdata[2:0] !== want.status)
                    report_mismatch("status", int'(m_tdata[2:0]), int'(want.status));
                if (m_tdata[17:3] !== want.task_id)
                    report_mismatch("woken_task", int'(m_tdata[17:3]), int'(want.task_id));
                if (m_tdata[18] !== want.file_wait)
                    report_mismatch("was_file_wait", int'(m_tdata[18]), int'(want.file_wait));
                if (m_tdata[dssq_pkg::M_DATA_W-1:19] !== '0)
                    report_mismatch("zero fill", int'(m_tdata[dssq_pkg::M_DATA_W-1:19]), 0);
                if (m_tlast !== want.last)
                    report_mismatch("tlast", int'(m_tlast), int'(want.last));
            end
        end
    end

    // Receiver: segments of steady, light, heavy or periodic stalls; long holds on request
    initial begin : receiver
        int seg_left;
        int style;
        int held;
        seg_left = 0;
        style = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req > 0) begin
                held = rx_hold_req;
                rx_hold_req = 0;
                m_tready <= 1'b0;
                repeat (held) @(posedge aclk);
            end else begin
                if (seg_left == 0) begin
                    style = $urandom_range(0, 3);
                    seg_left = $urandom_range(10, 120);
                end
                case (style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (seg_left[1:0] != 2'd0);
                endcase
                seg_left--;
            end
        end
    end

    task automatic test_empty_and_unused();
        send_word(dssq_pkg::MODE_TICK, '0, '0, '0, 1'b0);
        send_word(dssq_pkg::MODE_CANCEL, 15'd5, '0, '0, 1'b0);
        send_word(MODE_UNUSED, '1, SEC_MAX, SUB_MAX, 1'b1);
    endtask

    // Extremes of every field, an equal-deadline pair and a repeated task id
    task automatic test_sorted_insert();
        send_word(dssq_pkg::MODE_INSERT, 15'h7FFF, SEC_MAX, SUB_MAX, 1'b1);
        send_word(dssq_pkg::MODE_INSERT, 15'h0000, '0, '0, 1'b0);
        send_word(dssq_pkg::MODE_INSERT, 15'd10, 32'd100, 20'd999999, 1'b1);
        send_word(dssq_pkg::MODE_INSERT, 15'd11, 32'd100, 20'd999999, 1'b0);
        send_word(dssq_pkg::MODE_INSERT, 15'd10, 32'd50, 20'h80000, 1'b0);
    endtask

    task automatic test_cancel_and_expire();
        send_word(dssq_pkg::MODE_CANCEL, 15'd10, '0, '0, 1'b0);
        send_word(dssq_pkg::MODE_TICK, '0, 32'd99, SUB_MAX, 1'b0);
        send_word(dssq_pkg::MODE_TICK, '0, 32'd100, 20'd999998, 1'b0);
        send_word(dssq_pkg::MODE_TICK, '0, 32'd100, 20'd999999, 1'b0);
        send_word(dssq_pkg::MODE_TICK, '0, SEC_MAX, SUB_MAX, 1'b0);
        send_word(dssq_pkg::MODE_CANCEL, 15'h7FFF, '0, '0, 1'b0);
        send_word(dssq_pkg::MODE_TICK, '0, SEC_MAX, SUB_MAX, 1'b0);
    endtask

    task automatic pick_deadline(output logic [dssq_pkg::SEC_W-1:0] sec,
                                 output logic [dssq_pkg::SUB_W-1:0] sub);
        case ($urandom_range(0, 19))
            0: begin
                sec = $urandom;
                sub = 20'($urandom_range(0, 20'hFFFFF));
            end
            1: begin
                sec = now_sec;
                sub = 20'($urandom_range(1000000, 20'hFFFFF));
            end
            2: begin
                sec = now_sec;
                sub = now_sub;
            end
            3: begin
                sec = now_sec - 1;
                sub = 20'($urandom_range(0, 999999));
            end
            default: begin
                sec = now_sec + $urandom_range(0, 2);
                sub = 20'($urandom_range(0, 999999));
            end
        endcase
    endtask

    // Advance the wall clock, carrying subseconds into seconds
    task automatic advance_now();
        int step;
        step = $urandom_range(0, 600000);
        if (int'(now_sub) + step >= 1000000) begin
            now_sub = 20'(int'(now_sub) + step - 1000000);
            now_sec = now_sec + 1;
        end else begin
            now_sub = 20'(int'(now_sub) + step);
        end
        if ($urandom_range(0, 7) == 0)
            now_sec = now_sec + 1;
    endtask

    // Segments of insert-heavy, tick-heavy and mixed traffic around a moving clock
    task automatic test_random_traffic(input int n_items);
        int sent;
        int seg_len;
        int ins_w;
        int tick_w;
        int pick;
        logic [dssq_pkg::SEC_W-1:0] sec;
        logic [dssq_pkg::SUB_W-1:0] sub;
        logic [dssq_pkg::TASK_W-1:0] tid;
        for (int i = 0; i < 16; i++)
            task_pool[i] = 15'($urandom_range(0, 15'h7FFF));
        task_pool[0] = '0;
        task_pool[1] = '1;
        now_sec = $urandom;
        now_sub = 20'($urandom_range(0, 999999));
        sent = 0;
        while (sent < n_items) begin
            seg_len = $urandom_range(15, 40);
            tx_gaps_on = ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 2))
                0: begin ins_w = 75; tick_w = 12; end
                1: begin ins_w = 30; tick_w = 55; end
                default: begin ins_w = 50; tick_w = 30; end
            endcase
            if ($urandom_range(0, 9) == 0) begin
                now_sec = $urandom;
                now_sub = 20'($urandom_range(0, 999999));
            end
            for (int k = 0; k < seg_len && sent < n_items; k++) begin
                pick = $urandom_range(0, 99);
                tid = ($urandom_range(0, 4) == 0) ? 15'($urandom_range(0, 15'h7FFF))
                                                  : task_pool[$urandom_range(0, 15)];
                if (pick < ins_w) begin
                    pick_deadline(sec, sub);
                    send_word(dssq_pkg::MODE_INSERT, tid, sec, sub,
                              1'($urandom_range(0, 1)));
                    sent++;
                end else if (pick < ins_w + tick_w) begin
                    advance_now();
                    case ($urandom_range(0, 24))
                        0: send_word(dssq_pkg::MODE_TICK, tid, '0, '0,
                                     1'($urandom_range(0, 1)));
                        1: send_word(dssq_pkg::MODE_TICK, tid, SEC_MAX, SUB_MAX,
                                     1'($urandom_range(0, 1)));
                        default: send_word(dssq_pkg::MODE_TICK, tid, now_sec, now_sub,
                                           1'($urandom_range(0, 1)));
                    endcase
                    sent++;
                end else if (pick < 97) begin
                    send_word(dssq_pkg::MODE_CANCEL, tid, $urandom,
                              20'($urandom_range(0, 20'hFFFFF)), 1'($urandom_range(0, 1)));
                    sent++;
                end else begin
                    // noise: unused mode, ignored by the block
                    send_word(MODE_UNUSED, tid, $urandom,
                              20'($urandom_range(0, 20'hFFFFF)), 1'($urandom_range(0, 1)));
                end
            end
        end
        tx_gaps_on = 1'b1;
    endtask

    // Long receiver hold while inserts keep coming; overfill, then drain a full queue
    task automatic test_backpressure_and_full();
        send_word(dssq_pkg::MODE_TICK, '0, SEC_MAX, SUB_MAX, 1'b0);
        wait_replies_drained();
        tx_gaps_on = 1'b0;
        rx_hold_req = 300;
        for (int i = 0; i < dssq_pkg::QUEUE_DEPTH + 4; i++)
            send_word(dssq_pkg::MODE_INSERT, 15'($urandom_range(0, 15'h7FFF)),
                      32'd1000 + $urandom_range(0, 3), 20'($urandom_range(0, 999999)),
                      1'($urandom_range(0, 1)));
        wait_replies_drained();
        send_word(dssq_pkg::MODE_TICK, '0, SEC_MAX, SUB_MAX, 1'b0);
        wait_replies_drained();
        tx_gaps_on = 1'b1;
    endtask

    initial begin : main
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_and_unused();
        test_sorted_insert();
        test_cancel_and_expire();
        test_random_traffic(340);
        test_backpressure_and_full();
        wait_replies_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
